[sv/socu_pkg.sv]
// ----------------------------------------------------------------------------
// socu_pkg: shared types and constants of the substring occurrence counter
// Widths, register indexes, the per-cell compare setup and the lead-byte
// length decode used by the row control.
// ----------------------------------------------------------------------------
`default_nettype none

package socu_pkg;

  // longest pattern, one compare cell per pattern byte
  localparam int MaxPatBytes = 8;
  // width of the saturating occurrence count
  localparam int CountBits   = 16;

  localparam int PatIdxW     = (MaxPatBytes > 1) ? $clog2(MaxPatBytes) : 1;
  localparam int PatW        = 64;
  localparam int PatLenW     = 4;
  localparam int SeenW       = 4;
  localparam int SkipW       = 31;
  localparam int CharLeftW   = 3;
  localparam int StartW      = 32;

  // stream payload widths
  localparam int InDataW     = 40;
  localparam int InUserW     = 2;
  localparam int OutDataW    = ((CountBits + 7) / 8) * 8;

  // configuration port
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 64;
  localparam logic [CfgIdxW-1:0] RegPatternBytes  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPatternLength = 1'd1;

  // compare setup of one cell
  typedef struct packed {
    logic       use_en;
    logic [7:0] pat;
  } cell_cfg_t;

  // continuation bytes that follow a lead byte
  function automatic logic [CharLeftW-1:0] lead_extra(input logic [7:0] b);
    logic [CharLeftW-1:0] n;
    n = '0;
    if (b inside {[8'hC0:8'hDF]}) begin
      n = 3'd1;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      n = 3'd2;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      n = 3'd3;
    end else if (b inside {[8'hF8:8'hFB]}) begin
      n = 3'd4;
    end else if (b inside {[8'hFC:8'hFD]}) begin
      n = 3'd5;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/socu_cell.sv]
// ----------------------------------------------------------------------------
// socu_cell: one byte cell of the match window
// Holds one window byte, passes it to the older neighbor and compares the
// byte arriving from the newer neighbor against its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module socu_cell import socu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  input  wire cell_cfg_t  cfg_i,
  output logic      [7:0] byte_o,
  output logic            hit_o
);

  logic [7:0] byte_q;

  // window byte, moves one cell on each counted byte
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // compare the byte this cell takes on the shift
  assign hit_o = !cfg_i.use_en || (byte_i == cfg_i.pat);

endmodule

`default_nettype wire

[sv/socu_outbuf.sv]
// ----------------------------------------------------------------------------
// socu_outbuf: two-entry result buffer
// Output register plus a skid register, so the input side keeps taking
// bytes while one result waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module socu_outbuf import socu_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [CountBits-1:0] push_data_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic      [CountBits-1:0] data_o
);

  logic                 o_valid_q, o_valid_d;
  logic                 s_valid_q, s_valid_d;
  logic [CountBits-1:0] o_data_q, o_data_d;
  logic [CountBits-1:0] s_data_q, s_data_d;
  logic                 o_free;

  assign o_free = !o_valid_q || ready_i;

  // fill order: skid entry moves up first, then the new request
  always_comb begin
    o_valid_d = o_valid_q;
    o_data_d  = o_data_q;
    s_valid_d = s_valid_q;
    s_data_d  = s_data_q;
    if (o_free) begin
      if (s_valid_q) begin
        o_valid_d = 1'b1;
        o_data_d  = s_data_q;
        s_valid_d = push_i;
        s_data_d  = push_data_i;
      end else begin
        o_valid_d = push_i;
        o_data_d  = push_data_i;
      end
    end else if (push_i) begin
      s_valid_d = 1'b1;
      s_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_data_q <= o_data_d;
    s_data_q <= s_data_d;
  end

  assign room_o  = !s_valid_q;
  assign valid_o = o_valid_q;
  assign data_o  = o_data_q;

  // skid entry is only ever used behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> o_valid_q)
    else $error("skid entry held while output register empty");

endmodule

`default_nettype wire

[sv/substring_occurrence_counter_unit.sv]
// ----------------------------------------------------------------------------
// substring_occurrence_counter_unit: non-overlapping pattern count per row
// Bytes of a row pass a chain of compare cells; after an optional skip of
// leading UTF-8 characters, leftmost-first matches are counted and the
// saturating count goes out with the last byte of the row.
//
//   port group   dir   payload (lowest bit first)
//   s_axis       in    tdata: data_byte[7:0], start_position[39:8];
//                      tuser: first_byte, empty_row; tlast: last_byte
//   m_axis       out   tdata: match_count
//   cfg          in    write enable, index, 64-bit data
//
// one byte per clock while the result buffer has room; the window shift,
// the cell compares and the count update are worked out combinationally for each byte.
// a row's result is registered in the result buffer before it appears on m_axis.
// a two-entry result buffer lets input continue while m_axis stalls;
// s_axis_tready drops only when both entries hold results.
// reset takes effect at once, there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_occurrence_counter_unit import socu_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // byte stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // data_byte, start_position
  input  wire logic [InUserW-1:0]  s_axis_tuser,  // first_byte, empty_row
  input  wire logic                s_axis_tlast,
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [OutDataW-1:0] m_axis_tdata,  // match_count
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // input fields
  logic              in_accept;
  logic [7:0]        in_byte;
  logic [StartW-1:0] in_start;
  logic              in_first, in_last, in_empty;

  assign in_byte   = s_axis_tdata[7:0];
  assign in_start  = s_axis_tdata[8 +: StartW];
  assign in_first  = s_axis_tuser[0];
  assign in_empty  = s_axis_tuser[1];
  assign in_last   = s_axis_tlast;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // configuration registers
  logic [PatW-1:0]    pattern_q;
  logic [PatLenW-1:0] plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPatternBytes:  pattern_q <= cfg_data_i[PatW-1:0];
        RegPatternLength: plen_q    <= cfg_data_i[PatLenW-1:0];
        default: ;
      endcase
    end
  end

  // per-cell compare setup: the newest plen cells take the pattern in order
  logic                         plen_ok;
  cell_cfg_t [MaxPatBytes-1:0]  cell_cfg;

  assign plen_ok = (plen_q != '0) && (plen_q <= PatLenW'(MaxPatBytes));

  always_comb begin
    logic [PatLenW:0]   sum;
    logic [PatLenW:0]   pidx;
    for (int i = 0; i < MaxPatBytes; i++) begin
      sum  = (PatLenW+1)'(i) + {1'b0, plen_q};
      pidx = sum - (PatLenW+1)'(MaxPatBytes);
      cell_cfg[i].use_en = plen_ok && (sum >= (PatLenW+1)'(MaxPatBytes));
      cell_cfg[i].pat    = pattern_q[8*pidx[PatIdxW-1:0] +: 8];
    end
  end

  // cell chain, newest byte enters the top cell
  logic                   shift_en;
  logic [MaxPatBytes-1:0] hit;
  logic [7:0]             chain_byte [MaxPatBytes+1];

  assign chain_byte[MaxPatBytes] = in_byte;

  for (genvar g = 0; g < MaxPatBytes; g++) begin : g_cell
    socu_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .byte_i  (chain_byte[g+1]),
      .cfg_i   (cell_cfg[g]),
      .byte_o  (chain_byte[g]),
      .hit_o   (hit[g])
    );
  end

  // row state
  logic                 active_q, active_d;
  logic [SkipW-1:0]     skip_q, skip_d;
  logic [CharLeftW-1:0] cbl_q, cbl_d;
  logic [SeenW-1:0]     since_q, since_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 do_count;
  logic                 res_valid;
  logic [CountBits-1:0] res_count;

  // next row state for the byte on the input
  always_comb begin
    logic             sp_pos;
    logic [SeenW-1:0] seen;
    sp_pos    = !in_start[StartW-1] && (in_start != '0);
    active_d  = active_q;
    skip_d    = skip_q;
    cbl_d     = cbl_q;
    since_d   = since_q;
    count_d   = count_q;
    do_count  = 1'b0;
    seen      = (since_q == '1) ? since_q : since_q + 1'b1;
    if (in_first) begin
      active_d = sp_pos;
      skip_d   = sp_pos ? in_start[SkipW-1:0] - 1'b1 : '0;
      cbl_d    = '0;
      since_d  = '0;
      count_d  = '0;
      seen     = SeenW'(1);
    end
    if (active_d) begin
      if (cbl_d != '0) begin
        cbl_d = cbl_d - 1'b1;
      end else if (skip_d != '0) begin
        skip_d = skip_d - 1'b1;
        cbl_d  = lead_extra(in_byte);
      end else begin
        do_count = 1'b1;
        if (plen_ok && (seen >= plen_q) && (&hit)) begin
          if (count_d != '1) begin
            count_d = count_d + 1'b1;
          end
          since_d = '0;
        end else begin
          since_d = seen;
        end
      end
    end
    res_valid = in_last || in_empty;
    res_count = in_empty ? '0 : count_d;
    if (res_valid) begin
      active_d = 1'b0;
      skip_d   = '0;
      cbl_d    = '0;
      since_d  = '0;
      count_d  = '0;
    end
  end

  assign shift_en = in_accept && do_count && !in_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      skip_q   <= '0;
      cbl_q    <= '0;
      since_q  <= '0;
      count_q  <= '0;
    end else if (in_accept) begin
      active_q <= active_d;
      skip_q   <= skip_d;
      cbl_q    <= cbl_d;
      since_q  <= since_d;
      count_q  <= count_d;
    end
  end

  // result buffer
  logic                 buf_room;
  logic [CountBits-1:0] out_count;

  socu_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && res_valid),
    .push_data_i (res_count),
    .room_o      (buf_room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_count)
  );

  assign s_axis_tready = buf_room;
  assign m_axis_tdata  = OutDataW'(out_count);

  // no count is carried outside an open row
  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (count_q == '0) && (since_q == '0) && (skip_q == '0))
    else $error("row state left over outside an open row");

  // a pending multi-byte character only exists inside an open row
  a_cbl_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cbl_q != '0) |-> active_q)
    else $error("character bytes pending with no open row");

  // each row end brings a result onto the output
  a_row_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_valid) |=> m_axis_tvalid)
    else $error("row end accepted but no result shown");

  // backpressure only while a result waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

`default_nettype wire

[tb/substring_occurrence_counter_unit_test.sv]
// ----------------------------------------------------------------------------
// substring_occurrence_counter_unit_test: self-checking bench for the counter
// Streams byte rows with first/last marks, start positions and empty rows
// into the block, predicts each row's non-overlapping pattern count, and
// compares every result in order. Covers the pattern lengths at both ends
// and beyond the maximum, UTF-8 character skips, dropped and stray rows,
// and random idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_occurrence_counter_unit_test import socu_pkg::*; ();

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;

  // ------------------------------------------------------------------------
  // row count predictor and store of expected counts
  // ------------------------------------------------------------------------
  class count_scoreboard;
    logic [PatW-1:0]    pat_bytes;
    logic [PatLenW-1:0] pat_len;
    logic [63:0]        window;
    logic [SeenW-1:0]   since_match;
    logic [15:0]        running;
    logic [31:0]        skip_left;
    logic [2:0]         cont_left;
    bit                 active;
    logic [15:0]        expected_counts[$];
    int                 failures;
    int                 reported;

    function new();
      pat_bytes = '0;
      pat_len   = '0;
      failures  = 0;
      reported  = 0;
      clear_row();
    endfunction

    function void clear_row();
      window      = '0;
      since_match = '0;
      running     = '0;
      skip_left   = '0;
      cont_left   = '0;
      active      = 1'b0;
    endfunction

    // append one expected count at the tail
    function void queue_count(logic [15:0] c);
      expected_counts = {expected_counts, c};
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegPatternBytes) begin
        pat_bytes = val;
      end else if (idx == RegPatternLength) begin
        pat_len = val[PatLenW-1:0];
      end
    endfunction

    // continuation bytes implied by a lead byte
    function logic [2:0] tail_bytes(logic [7:0] b);
      if (b >= 8'hC0 && b <= 8'hDF) return 3'd1;
      if (b >= 8'hE0 && b <= 8'hEF) return 3'd2;
      if (b >= 8'hF0 && b <= 8'hF7) return 3'd3;
      if (b >= 8'hF8 && b <= 8'hFB) return 3'd4;
      if (b >= 8'hFC && b <= 8'hFD) return 3'd5;
      return 3'd0;
    endfunction

    // shift one counted byte in and test the window tail
    function void count_one(logic [7:0] b);
      logic [4:0]  seen;
      logic [63:0] mask;
      logic [63:0] tail;
      seen = {1'b0, since_match} + 5'd1;
      if (seen > 5'd15) seen = 5'd15;
      window = {b, window[63:8]};
      if (pat_len >= 1 && pat_len <= MaxPatBytes && seen >= pat_len) begin
        mask = (pat_len == 8) ? '1 : ((64'd1 << (8 * pat_len)) - 64'd1);
        tail = window >> (64 - 8 * pat_len);
        if (tail == (pat_bytes & mask)) begin
          if (running != 16'hFFFF) running = running + 16'd1;
          since_match = '0;
          return;
        end
      end
      since_match = seen[SeenW-1:0];
    endfunction

    function void note_request(logic [7:0] b, bit is_first, bit is_last, bit is_empty,
                               logic [31:0] start_word);
      if (is_empty) begin
        clear_row();
        queue_count(16'd0);
        return;
      end
      if (is_first) begin
        clear_row();
        if (start_word != 0 && !start_word[31]) begin
          active    = 1'b1;
          skip_left = start_word - 32'd1;
        end
      end
      if (active) begin
        if (cont_left > 0) begin
          cont_left = cont_left - 3'd1;
        end else if (skip_left > 0) begin
          skip_left = skip_left - 32'd1;
          cont_left = tail_bytes(b);
        end else begin
          count_one(b);
        end
      end
      if (is_last) begin
        queue_count(running);
        clear_row();
      end
    endfunction

    function void check_count(logic [15:0] actual);
      logic [15:0] want;
      if (expected_counts.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: match_count %0d", actual);
        end
        return;
      end
      want = expected_counts.pop_front();
      if (actual !== want) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("match_count mismatch: expected %0d, actual %0d", want, actual);
        end
      end
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // clock, reset and block signals
  // ------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;  // data_byte, start_position
  logic [InUserW-1:0]  s_axis_tuser   = '0;  // first_byte, empty_row
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // match_count
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  count_scoreboard     sb;
  int                  src_idle_pct   = 0;
  int                  snk_idle_pct   = 0;
  logic                hold_toggle    = 1'b0;
  logic                hold_seen      = 1'b0;
  int unsigned         hold_left      = 0;
  int unsigned         cycle_count    = 0;
  logic [PatW-1:0]     cur_pat        = '0;
  int                  cur_len        = 0;

  always #5 clk_i = ~clk_i;

  substring_occurrence_counter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("substring_occurrence_counter_unit_test failed");
      $finish;
    end
  end

  // result side ready, with random stalls and an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tlast,
                        s_axis_tuser[1], s_axis_tdata[39:8]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_count(m_axis_tdata[15:0]);
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last,
                           input bit is_empty, input logic [31:0] start_word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {start_word, b};
    s_axis_tuser  <= {is_empty, is_first};
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and wait for every expected count
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers; the task does not check that the block is idle
  task automatic load_pattern(input logic [PatW-1:0] pat, input int len);
    logic [CfgDataW-1:0] len_word;
    len_word      = {$urandom(), $urandom()};
    len_word[3:0] = len[3:0];
    cur_pat       = pat;
    cur_len       = len;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegPatternBytes;
    cfg_data_i <= pat;
    sb.write_reg(RegPatternBytes, pat);
    @(posedge clk_i);
    cfg_idx_i  <= RegPatternLength;
    cfg_data_i <= len_word;
    sb.write_reg(RegPatternLength, len_word);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // row bytes drawn mostly from the pattern so that matches are frequent
  function automatic logic [7:0] pick_byte();
    int r;
    int span;
    r    = $urandom_range(99);
    span = (cur_len >= 1 && cur_len <= 8) ? cur_len : 8;
    if (r < 55) return cur_pat[8 * $urandom_range(span - 1) +: 8];
    if (r < 80) return ($urandom_range(1) == 1) ? 8'h61 : 8'h62;
    if (r < 90) return 8'($urandom_range(8'hFD, 8'hC0));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_start();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 80) return $urandom_range(12, 4);
    if (r < 85) return 32'd0;
    if (r < 90) return {1'b1, 31'($urandom())};
    return $urandom();
  endfunction

  // well-formed rows with random content, plus empty rows and broken rows
  task automatic run_random_rows(input int n_bytes);
    int sent;
    int r;
    int len;
    logic [31:0] sp;
    sent = 0;
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      if (r < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
        sp  = pick_start();
        for (int i = 0; i < len; i++) begin
          send_byte(pick_byte(), i == 0, i == len - 1, 1'b0, (i == 0) ? sp : $urandom());
        end
        sent += len;
      end else if (r < 90) begin
        send_byte(8'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
                  $urandom());
      end else if (r < 95) begin
        // stray byte with no first mark
        send_byte(pick_byte(), 1'b0, 1'($urandom_range(1)), 1'b0, $urandom());
      end else begin
        // row without last byte, dropped by the next first byte
        len = $urandom_range(6, 1);
        sp  = pick_start();
        for (int i = 0; i < len; i++) begin
          send_byte(pick_byte(), i == 0, 1'b0, 1'b0, (i == 0) ? sp : $urandom());
        end
      end
    end
  endtask

  function automatic logic [PatW-1:0] random_pattern();
    logic [PatW-1:0] p;
    p = {$urandom(), $urandom()};
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(3))
        0: p[8*k +: 8] = 8'h61;
        1: p[8*k +: 8] = 8'h62;
        2: p[8*k +: 8] = 8'hC3;
        default: p[8*k +: 8] = 8'hFF;
      endcase
    end
    return p;
  endfunction

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  int phase_len[8] = '{2, 1, 8, 0, 3, 15, 5, 9};

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, pattern "aa"
    src_idle_pct = 33;
    snk_idle_pct = 47;
    load_pattern(64'h6161, 2);
    for (int i = 0; i < 3; i++) send_byte(8'h61, i == 0, i == 2, 1'b0, 32'd1);
    // skip of one two-byte character
    send_byte(8'hC3, 1'b1, 1'b0, 1'b0, 32'd2);
    for (int i = 0; i < 3; i++) send_byte(8'h61, 1'b0, i == 2, 1'b0, $urandom());
    // start position zero, most negative, most positive
    send_byte(8'h61, 1'b1, 1'b0, 1'b0, 32'd0);
    send_byte(8'h61, 1'b0, 1'b1, 1'b0, 32'd0);
    send_byte(8'h61, 1'b1, 1'b1, 1'b0, 32'h8000_0000);
    send_byte(8'h61, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF);
    send_byte(8'h61, 1'b0, 1'b1, 1'b0, 32'h7FFF_FFFF);
    // empty row with no marks
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1, $urandom());
    // bytes outside a row
    send_byte(8'h61, 1'b0, 1'b1, 1'b0, 32'd1);
    send_byte(8'h61, 1'b0, 1'b0, 1'b0, 32'd1);
    // first byte while a row is open
    send_byte(8'h61, 1'b1, 1'b0, 1'b0, 32'd1);
    send_byte(8'h61, 1'b1, 1'b0, 1'b0, 32'd1);
    send_byte(8'h61, 1'b0, 1'b1, 1'b0, 32'd1);
    // registers rewritten in the middle of a row
    send_byte(8'h61, 1'b1, 1'b0, 1'b0, 32'd1);
    send_byte(8'h62, 1'b0, 1'b0, 1'b0, 32'd1);
    drain_results();
    load_pattern(64'h6261, 2);
    send_byte(8'h61, 1'b0, 1'b0, 1'b0, 32'd1);
    send_byte(8'h62, 1'b0, 1'b1, 1'b0, 32'd1);
    drain_results();
    // full-width pattern of zero bytes against a row of zero bytes
    load_pattern(64'h0, 8);
    for (int i = 0; i < 8; i++) send_byte(8'h00, i == 0, i == 7, 1'b0, 32'd1);
    drain_results();

    // random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        src_idle_pct = 33;
        snk_idle_pct = 47;
      end else if (p < 6) begin
        src_idle_pct = 47;
        snk_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      load_pattern((p == 4) ? '1 : random_pattern(), phase_len[p]);
      // long result hold-off while input keeps coming
      if (p == 6) hold_toggle <= ~hold_toggle;
      run_random_rows(160);
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.expected_counts.size() != 0) sb.failures++;
    if (sb.failures == 0) begin
      $display("substring_occurrence_counter_unit_test passed");
    end else begin
      $display("substring_occurrence_counter_unit_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/socu_pkg.sv
sv/socu_cell.sv
sv/socu_outbuf.sv
sv/substring_occurrence_counter_unit.sv
tb/substring_occurrence_counter_unit_test.sv
